// File: hw/rtl/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg: shared types and tables for the selective scan block
// Beat layouts of both channels, default parameter values and the fixed
// Q30 tables used by the exponential and log interpolators.
// ----------------------------------------------------------------------------
package ssf_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int INNER_CHANNELS_DEF = 64;
    localparam int STATE_SLOTS_DEF    = 16;
    localparam int FRAC_BITS_DEF      = 16;

    // Fixed field widths of the beats.
    localparam int CHANNEL_W = 6;
    localparam int SLOT_W    = 4;
    localparam int DATA_W    = 32;

    // log2(e) in Q30.
    localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;

    // One input beat.
    typedef struct packed {
        logic [CHANNEL_W-1:0]     channel;
        logic [SLOT_W-1:0]        slot;
        logic                     first_token;
        logic                     last_slot;
        logic signed [DATA_W-1:0] delta_pre;
        logic signed [DATA_W-1:0] a_log;
        logic signed [DATA_W-1:0] b_val;
        logic signed [DATA_W-1:0] c_val;
        logic signed [DATA_W-1:0] x_pre;
        logic signed [DATA_W-1:0] gate_pre;
        logic signed [DATA_W-1:0] d_skip;
    } in_beat_t;

    // One result beat.
    typedef struct packed {
        logic [CHANNEL_W-1:0]     out_channel;
        logic signed [DATA_W-1:0] scan_out;
        logic signed [DATA_W-1:0] gated_out;
    } out_beat_t;

    // 2^(k/16) in Q30 for k = 0..16.
    function automatic logic [31:0] pow2_tab(input logic [4:0] idx);
        logic [31:0] val;
        unique case (idx)
            5'd0:    val = 32'd1073741824;
            5'd1:    val = 32'd1121280436;
            5'd2:    val = 32'd1170923762;
            5'd3:    val = 32'd1222764985;
            5'd4:    val = 32'd1276901417;
            5'd5:    val = 32'd1333434672;
            5'd6:    val = 32'd1392470869;
            5'd7:    val = 32'd1454120821;
            5'd8:    val = 32'd1518500250;
            5'd9:    val = 32'd1585730000;
            5'd10:   val = 32'd1655936266;
            5'd11:   val = 32'd1729250827;
            5'd12:   val = 32'd1805811301;
            5'd13:   val = 32'd1885761398;
            5'd14:   val = 32'd1969251188;
            5'd15:   val = 32'd2056437387;
            5'd16:   val = 32'd2147483648;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

    // ln(1 + k/16) in Q30 for k = 0..16.
    function automatic logic [31:0] ln1p_tab(input logic [4:0] idx);
        logic [31:0] val;
        unique case (idx)
            5'd0:    val = 32'd0;
            5'd1:    val = 32'd65095192;
            5'd2:    val = 32'd126468572;
            5'd3:    val = 32'd184522808;
            5'd4:    val = 32'd239598564;
            5'd5:    val = 32'd291986604;
            5'd6:    val = 32'd341937090;
            5'd7:    val = 32'd389666807;
            5'd8:    val = 32'd435364845;
            5'd9:    val = 32'd479197128;
            5'd10:   val = 32'd521310048;
            5'd11:   val = 32'd561833416;
            5'd12:   val = 32'd600882877;
            5'd13:   val = 32'd638561895;
            5'd14:   val = 32'd674963409;
            5'd15:   val = 32'd710171213;
            5'd16:   val = 32'd744261118;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

// File: hw/rtl/selective_scan_forward.sv
// ----------------------------------------------------------------------------
// selective_scan_forward: fixed-point selective state-space scan
// The softplus step has a log form, a pass-through form and a plain
// exponential form. Each sigmoid division holds the sequencer.
// Throughput: one beat at a time. The shared multiplier and the serial
// divider run under one sequencer; s_ready is high only when idle, and a
// result that waits on m_ready holds the sequencer.
// Reset (aresetn, synchronous) clears the sequencer, the accumulator and the
// output valid; the hidden state memory keeps its contents.
// ----------------------------------------------------------------------------
module selective_scan_forward #(
    parameter int INNER_CHANNELS = ssf_pkg::INNER_CHANNELS_DEF,
    parameter int STATE_SLOTS    = ssf_pkg::STATE_SLOTS_DEF,
    parameter int FRAC_BITS      = ssf_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ssf_pkg::in_beat_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ssf_pkg::out_beat_t m_data
);
    import ssf_pkg::*;

    localparam int DEPTH    = INNER_CHANNELS * STATE_SLOTS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SEG      = FRAC_BITS - 4;
    localparam int NUM_W    = 2 * FRAC_BITS + 1;
    localparam int DEN_W    = FRAC_BITS + 2;
    localparam int Q_W      = FRAC_BITS + 1;
    localparam int LN_SHIFT = 30 - FRAC_BITS;

    localparam logic [31:0]        ONE_U      = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [31:0] THIRTY     = 32'(30 * (1 << FRAC_BITS));
    localparam logic signed [31:0] NEG_THIRTY = -THIRTY;
    localparam logic signed [63:0] LIM        = 64'(64) << FRAC_BITS;
    localparam logic signed [63:0] NEG_LIM    = -LIM;
    localparam logic [31:0]        LN_TOP     = ln1p_tab(5'd16) >> LN_SHIFT;
    localparam logic signed [8:0]  EXP_BIAS   = 9'(FRAC_BITS - 30);
    localparam logic signed [63:0] S32_MAX    = 64'sh7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN    = -64'sh8000_0000;
    localparam logic signed [63:0] S48_MAX    = 64'sh7FFF_FFFF_FFFF;
    localparam logic signed [63:0] S48_MIN    = -64'sh8000_0000_0000;

    // Sequencer states.
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_SP0  = 5'd1;
    localparam logic [4:0] ST_SP1  = 5'd2;
    localparam logic [4:0] ST_SP2  = 5'd3;
    localparam logic [4:0] ST_SP3  = 5'd4;
    localparam logic [4:0] ST_AE0  = 5'd5;
    localparam logic [4:0] ST_AE1  = 5'd6;
    localparam logic [4:0] ST_AB0  = 5'd7;
    localparam logic [4:0] ST_AB1  = 5'd8;
    localparam logic [4:0] ST_SX1  = 5'd9;
    localparam logic [4:0] ST_SX2  = 5'd10;
    localparam logic [4:0] ST_SX3  = 5'd11;
    localparam logic [4:0] ST_BB   = 5'd12;
    localparam logic [4:0] ST_H0   = 5'd13;
    localparam logic [4:0] ST_H1   = 5'd14;
    localparam logic [4:0] ST_C0   = 5'd15;
    localparam logic [4:0] ST_Y0   = 5'd16;
    localparam logic [4:0] ST_G1   = 5'd17;
    localparam logic [4:0] ST_G2   = 5'd18;
    localparam logic [4:0] ST_G3   = 5'd19;
    localparam logic [4:0] ST_G4   = 5'd20;
    localparam logic [4:0] ST_EXP0 = 5'd21;
    localparam logic [4:0] ST_EXP1 = 5'd22;
    localparam logic [4:0] ST_EXP2 = 5'd23;

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = (v > S32_MAX) ? S32_MAX : ((v < S32_MIN) ? S32_MIN : v);
        return c[31:0];
    endfunction

    // Saturate to the signed 48-bit range.
    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = (v > S48_MAX) ? S48_MAX : ((v < S48_MIN) ? S48_MIN : v);
        return c[47:0];
    endfunction

    // Clamp an exponent argument to +-64.0.
    function automatic logic signed [31:0] clamp_lim(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = (v > LIM) ? LIM : ((v < NEG_LIM) ? NEG_LIM : v);
        return c[31:0];
    endfunction

    // Minus the magnitude, widened so that the most negative input is exact.
    function automatic logic signed [63:0] neg_abs(input logic signed [31:0] v);
        return (v < 0) ? 64'(v) : -64'(v);
    endfunction

    logic [4:0]         state_reg, state_next;
    logic [4:0]         ret_reg, ret_next;
    logic               wait_reg, wait_next;
    in_beat_t           in_reg, in_next;
    logic signed [31:0] exp_x_reg, exp_x_next;
    logic signed [31:0] exp_res_reg, exp_res_next;
    logic signed [7:0]  ex_n_reg, ex_n_next;
    logic [31:0]        ex_base_reg, ex_base_next;
    logic [31:0]        ln_base_reg, ln_base_next;
    logic signed [31:0] delta_reg, delta_next;
    logic signed [31:0] abar_reg, abar_next;
    logic signed [31:0] xt_reg, xt_next;
    logic signed [31:0] bbar_reg, bbar_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [63:0] t1_reg, t1_next;
    logic signed [47:0] acc_reg, acc_next;
    logic               m_valid_reg, m_valid_next;
    out_beat_t          m_data_reg, m_data_next;

    logic               mul_load;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic signed [63:0] prod_sh;

    logic               div_start, div_busy, div_done;
    logic [NUM_W-1:0]   div_num, div_quot;
    logic [DEN_W-1:0]   div_den;
    logic signed [31:0] sig_val;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic signed [31:0] mem_rdata;
    logic [31:0]        pos_full;
    logic               in_range;
    logic signed [31:0] hprev;
    logic signed [31:0] h_val;

    logic signed [63:0] y_full;
    logic signed [63:0] ex_n_full;
    logic [3:0]         ex_idx;
    logic [SEG-1:0]     ex_rem;
    logic [31:0]        ex_diff;
    logic [31:0]        ex_m;
    logic signed [8:0]  ex_s;
    logic signed [8:0]  ex_sh;
    logic [31:0]        ex_val;
    logic [3:0]         ln_idx;
    logic [SEG-1:0]     ln_rem;
    logic [31:0]        ln_diff;
    logic [31:0]        ln_m;
    logic signed [31:0] x_pos;
    logic signed [31:0] gs_val;

    // Shared units.
    ssf_mul u_mul (
        .aclk (aclk),
        .load (mul_load),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    ssf_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    ssf_hstore #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_hstore (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (h_val),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    // Store address and range check of the current beat.
    assign pos_full = 32'(in_reg.channel) * 32'(STATE_SLOTS) + 32'(in_reg.slot);
    assign in_range = (32'(in_reg.channel) < 32'(INNER_CHANNELS)) &&
                      (32'(in_reg.slot) < 32'(STATE_SLOTS));
    assign mem_addr = pos_full[ADDR_W-1:0];
    assign hprev    = (in_reg.first_token || !in_range) ? 32'sd0 : mem_rdata;

    // Product scaled back to the fixed-point format.
    assign prod_sh = prod >>> FRAC_BITS;
    assign h_val   = sat32(t1_reg + prod_sh);
    assign gs_val  = prod_sh[31:0];
    assign sig_val = $signed(32'(div_quot[Q_W-1:0]));

    // Exponential: split of the base-2 exponent and table interpolation.
    assign y_full    = prod >>> 30;
    assign ex_n_full = y_full >>> FRAC_BITS;
    assign ex_idx    = y_full[FRAC_BITS-1:SEG];
    assign ex_rem    = y_full[SEG-1:0];
    assign ex_diff   = pow2_tab({1'b0, ex_idx} + 5'd1) - pow2_tab({1'b0, ex_idx});
    assign ex_m      = ex_base_reg + prod[SEG+31:SEG];
    assign ex_s      = {ex_n_reg[7], ex_n_reg} + EXP_BIAS;
    assign ex_sh     = -ex_s;

    always_comb begin
        if (ex_s > 9'sd0) begin
            ex_val = 32'h7FFF_FFFF;
        end else if (ex_s == 9'sd0) begin
            ex_val = ex_m;
        end else if (ex_sh >= 9'sd32) begin
            ex_val = 32'd0;
        end else begin
            ex_val = ex_m >> ex_sh[4:0];
        end
    end

    // Log interpolation on the exponential result.
    assign ln_idx  = exp_res_reg[SEG+3:SEG];
    assign ln_rem  = exp_res_reg[SEG-1:0];
    assign ln_diff = ln1p_tab({1'b0, ln_idx} + 5'd1) - ln1p_tab({1'b0, ln_idx});
    assign ln_m    = ln_base_reg + prod[SEG+31:SEG];
    assign x_pos   = (in_reg.delta_pre > 0) ? in_reg.delta_pre : 32'sd0;

    // Sequencer: every multiply issue is followed by a raised wait_reg.
    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        wait_next    = 1'b0;
        in_next      = in_reg;
        exp_x_next   = exp_x_reg;
        exp_res_next = exp_res_reg;
        ex_n_next    = ex_n_reg;
        ex_base_next = ex_base_reg;
        ln_base_next = ln_base_reg;
        delta_next   = delta_reg;
        abar_next    = abar_reg;
        xt_next      = xt_reg;
        bbar_next    = bbar_reg;
        y_next       = y_reg;
        t1_next      = t1_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mul_load     = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_num      = '0;
        div_den      = '0;
        mem_we       = 1'b0;

        if (!wait_reg) begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_next    = s_data;
                        state_next = ST_SP0;
                    end
                end
                // Softplus: pass-through, plain exponential or log1p form.
                ST_SP0: begin
                    if (in_reg.delta_pre > THIRTY) begin
                        delta_next = in_reg.delta_pre;
                        state_next = ST_AE0;
                    end else if (in_reg.delta_pre < NEG_THIRTY) begin
                        exp_x_next = clamp_lim(64'(in_reg.delta_pre));
                        ret_next   = ST_SP3;
                        state_next = ST_EXP0;
                    end else begin
                        exp_x_next = clamp_lim(neg_abs(in_reg.delta_pre));
                        ret_next   = ST_SP1;
                        state_next = ST_EXP0;
                    end
                end
                ST_SP1: begin
                    if ($unsigned(exp_res_reg) >= ONE_U) begin
                        delta_next = x_pos + $signed(LN_TOP);
                        state_next = ST_AE0;
                    end else begin
                        ln_base_next = ln1p_tab({1'b0, ln_idx});
                        mul_load     = 1'b1;
                        mul_a        = $signed(ln_diff);
                        mul_b        = $signed(32'(ln_rem));
                        wait_next    = 1'b1;
                        state_next   = ST_SP2;
                    end
                end
                ST_SP2: begin
                    delta_next = x_pos + $signed(ln_m >> LN_SHIFT);
                    state_next = ST_AE0;
                end
                ST_SP3: begin
                    delta_next = exp_res_reg;
                    state_next = ST_AE0;
                end
                // Decay rate A = -exp(a_log), then delta * A.
                ST_AE0: begin
                    exp_x_next = clamp_lim(64'(in_reg.a_log));
                    ret_next   = ST_AE1;
                    state_next = ST_EXP0;
                end
                ST_AE1: begin
                    mul_load   = 1'b1;
                    mul_a      = delta_reg;
                    mul_b      = -exp_res_reg;
                    wait_next  = 1'b1;
                    state_next = ST_AB0;
                end
                ST_AB0: begin
                    exp_x_next = clamp_lim(prod_sh);
                    ret_next   = ST_AB1;
                    state_next = ST_EXP0;
                end
                // Discretized decay, then the sigmoid of x_pre.
                ST_AB1: begin
                    abar_next  = exp_res_reg;
                    exp_x_next = clamp_lim(neg_abs(in_reg.x_pre));
                    ret_next   = ST_SX1;
                    state_next = ST_EXP0;
                end
                ST_SX1: begin
                    div_start  = 1'b1;
                    div_num    = (in_reg.x_pre >= 0) ? (NUM_W'(1) << (2 * FRAC_BITS))
                                                     : (NUM_W'(exp_res_reg) << FRAC_BITS);
                    div_den    = DEN_W'(ONE_U) + DEN_W'(exp_res_reg);
                    state_next = ST_SX2;
                end
                ST_SX2: begin
                    if (div_done) begin
                        mul_load   = 1'b1;
                        mul_a      = in_reg.x_pre;
                        mul_b      = sig_val;
                        wait_next  = 1'b1;
                        state_next = ST_SX3;
                    end
                end
                ST_SX3: begin
                    xt_next    = prod_sh[31:0];
                    mul_load   = 1'b1;
                    mul_a      = delta_reg;
                    mul_b      = in_reg.b_val;
                    wait_next  = 1'b1;
                    state_next = ST_BB;
                end
                // State update h = abar*hprev + bbar*xt.
                ST_BB: begin
                    bbar_next  = sat32(prod_sh);
                    mul_load   = 1'b1;
                    mul_a      = abar_reg;
                    mul_b      = hprev;
                    wait_next  = 1'b1;
                    state_next = ST_H0;
                end
                ST_H0: begin
                    t1_next    = prod_sh;
                    mul_load   = 1'b1;
                    mul_a      = bbar_reg;
                    mul_b      = xt_reg;
                    wait_next  = 1'b1;
                    state_next = ST_H1;
                end
                ST_H1: begin
                    mem_we     = in_range;
                    mul_load   = 1'b1;
                    mul_a      = in_reg.c_val;
                    mul_b      = h_val;
                    wait_next  = 1'b1;
                    state_next = ST_C0;
                end
                // Accumulate c*h; on the last slot add the skip term.
                ST_C0: begin
                    acc_next = sat48(64'(acc_reg) + prod_sh);
                    if (in_reg.last_slot) begin
                        mul_load   = 1'b1;
                        mul_a      = in_reg.d_skip;
                        mul_b      = xt_reg;
                        wait_next  = 1'b1;
                        state_next = ST_Y0;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
                ST_Y0: begin
                    y_next     = sat32(64'(acc_reg) + prod_sh);
                    acc_next   = '0;
                    exp_x_next = clamp_lim(neg_abs(in_reg.gate_pre));
                    ret_next   = ST_G1;
                    state_next = ST_EXP0;
                end
                // Gate: silu(gate_pre) * y.
                ST_G1: begin
                    div_start  = 1'b1;
                    div_num    = (in_reg.gate_pre >= 0) ? (NUM_W'(1) << (2 * FRAC_BITS))
                                                        : (NUM_W'(exp_res_reg) << FRAC_BITS);
                    div_den    = DEN_W'(ONE_U) + DEN_W'(exp_res_reg);
                    state_next = ST_G2;
                end
                ST_G2: begin
                    if (div_done) begin
                        mul_load   = 1'b1;
                        mul_a      = in_reg.gate_pre;
                        mul_b      = sig_val;
                        wait_next  = 1'b1;
                        state_next = ST_G3;
                    end
                end
                ST_G3: begin
                    mul_load   = 1'b1;
                    mul_a      = gs_val;
                    mul_b      = y_reg;
                    wait_next  = 1'b1;
                    state_next = ST_G4;
                end
                ST_G4: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_next            = 1'b1;
                        m_data_next.out_channel = in_reg.channel;
                        m_data_next.scan_out    = y_reg;
                        m_data_next.gated_out   = sat32(prod_sh);
                        state_next              = ST_IDLE;
                    end
                end
                // Exponential subroutine, returns to ret_reg.
                ST_EXP0: begin
                    mul_load   = 1'b1;
                    mul_a      = exp_x_reg;
                    mul_b      = LOG2E_Q30;
                    wait_next  = 1'b1;
                    state_next = ST_EXP1;
                end
                ST_EXP1: begin
                    ex_n_next    = ex_n_full[7:0];
                    ex_base_next = pow2_tab({1'b0, ex_idx});
                    mul_load     = 1'b1;
                    mul_a        = $signed(ex_diff);
                    mul_b        = $signed(32'(ex_rem));
                    wait_next    = 1'b1;
                    state_next   = ST_EXP2;
                end
                ST_EXP2: begin
                    exp_res_next = $signed(ex_val);
                    state_next   = ret_reg;
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            wait_reg    <= 1'b0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            wait_reg    <= wait_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
        in_reg      <= in_next;
        exp_x_reg   <= exp_x_next;
        exp_res_reg <= exp_res_next;
        ex_n_reg    <= ex_n_next;
        ex_base_reg <= ex_base_next;
        ln_base_reg <= ln_base_next;
        delta_reg   <= delta_next;
        abar_reg    <= abar_next;
        xt_reg      <= xt_next;
        bbar_reg    <= bbar_next;
        y_reg       <= y_next;
        t1_reg      <= t1_next;
        m_data_reg  <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // An accepted beat always starts the softplus step.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_SP0)
        else $error("accepted beat did not start the sequence");

    // A new result always leaves the accumulator cleared.
    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> acc_reg == '0)
        else $error("accumulator not cleared with result");

    // The divider is never restarted while it runs.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // Every multiply issue is followed by a raised wait_reg.
    a_mul_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_load |=> wait_reg)
        else $error("multiplier product used without wait");

endmodule

// File: hw/rtl/ssf_mul.sv
// ----------------------------------------------------------------------------
// ssf_mul: shared signed multiplier
// Registers a pair of 32-bit signed operands on load and registers their
// full 64-bit product in the following cycle.
// ----------------------------------------------------------------------------
module ssf_mul (
    input  logic               aclk,
    input  logic               load,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [63:0] prod
);
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [63:0] prod_reg;

    // Operand capture and product register.
    always_ff @(posedge aclk) begin
        if (load) begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        prod_reg <= 64'(a_reg) * 64'(b_reg);
    end

    assign prod = prod_reg;

endmodule

// File: hw/rtl/ssf_div.sv
// ----------------------------------------------------------------------------
// ssf_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle over the NUM_W numerator bits.
// Done pulses for one cycle when the quotient is ready; it then holds.
// ----------------------------------------------------------------------------
module ssf_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 18
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             ge;

    // One restoring step on the partial remainder.
    assign trial = {r_reg, q_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, d_reg};

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = {q_reg[NUM_W-2:0], ge};
            r_next   = ge ? DEN_W'(trial - {1'b0, d_reg}) : trial[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: hw/rtl/ssf_hstore.sv
// ----------------------------------------------------------------------------
// ssf_hstore: hidden state memory
// One write port and one read port, read data registered. Contents are not
// cleared by reset.
// ----------------------------------------------------------------------------
module ssf_hstore #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic signed [31:0] wdata,
    input  logic [ADDR_W-1:0]  raddr,
    output logic signed [31:0] rdata
);
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the selective scan block
// Drives token/channel/slot beats through the input channel and predicts each
// result with a fixed-point scan model kept in the bench. Each result beat is
// compared field by field against the oldest prediction. The sender idles in
// random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
    import ssf_pkg::*;

    localparam int     N_CH       = 64;
    localparam int     N_SLOT     = 16;
    localparam int     FB         = 16;
    localparam int     SEG        = FB - 4;
    localparam longint ONE        = 64'sd1 << FB;
    localparam longint L2E        = 64'sd1549082005;
    localparam longint S32_HI     = 64'sd2147483647;
    localparam longint S32_LO     = -64'sd2147483648;
    localparam longint S48_HI     = (64'sd1 <<< 47) - 1;
    localparam longint S48_LO     = -(64'sd1 <<< 47);
    localparam int     HOLD_LEN   = 2000;
    localparam int     TAIL_LEN   = 300;
    localparam longint CYCLE_CAP  = 3000000;
    localparam int     RAND_ITEMS = 1650;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    // Interpolation tables, 2^(k/16) and ln(1+k/16) in Q30.
    longint pow2_q30 [17] = '{
        1073741824, 1121280436, 1170923762, 1222764985, 1276901417,
        1333434672, 1392470869, 1454120821, 1518500250, 1585730000,
        1655936266, 1729250827, 1805811301, 1885761398, 1969251188,
        2056437387, 64'sd2147483648};
    longint ln1p_q30 [17] = '{
        0, 65095192, 126468572, 184522808, 239598564,
        291986604, 341937090, 389666807, 435364845, 479197128,
        521310048, 561833416, 600882877, 638561895, 674963409,
        710171213, 744261118};

    // Scan state mirrored in the bench.
    longint    hid_mem [N_CH*N_SLOT];
    bit        hid_written [N_CH*N_SLOT];
    longint    dot_acc;
    out_beat_t result_q [$];
    int        errors;
    longint    cycles;

    // Receiver hold-off handshake between the stimulus and the stall process.
    int hold_req  = 0;
    int hold_ack  = 0;
    int hold_left = 0;

    selective_scan_forward i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Cycle count and run limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint q_exp(longint x);
        longint lim;
        longint y;
        longint n;
        longint fr;
        longint rem;
        longint m;
        longint s;
        int     idx;
        lim = 64'sd64 <<< FB;
        x   = sat(x, -lim, lim);
        y   = (x * L2E) >>> 30;
        n   = y >>> FB;
        fr  = y & (ONE - 1);
        idx = int'(fr >> SEG) & 15;
        rem = fr & ((64'sd1 << SEG) - 1);
        m   = pow2_q30[idx] + (((pow2_q30[idx+1] - pow2_q30[idx]) * rem) >> SEG);
        s   = n + FB - 30;
        if (s >= 0) begin
            if (s > 31) return S32_HI;
            m = m << s;
            return (m > S32_HI) ? S32_HI : m;
        end
        if (-s >= 63) return 0;
        return m >> (-s);
    endfunction

    function automatic longint q_ln1p(longint u);
        longint uu;
        longint rem;
        longint m;
        int     idx;
        uu  = sat(u, 0, ONE);
        idx = int'(uu >> SEG);
        if (idx >= 16) return ln1p_q30[16] >> (30 - FB);
        rem = uu & ((64'sd1 << SEG) - 1);
        m   = ln1p_q30[idx] + (((ln1p_q30[idx+1] - ln1p_q30[idx]) * rem) >> SEG);
        return m >> (30 - FB);
    endfunction

    function automatic longint q_sigmoid(longint x);
        longint e;
        e = q_exp((x < 0) ? x : -x);
        if (x >= 0) return (ONE << FB) / (ONE + e);
        return (e << FB) / (ONE + e);
    endfunction

    function automatic longint q_silu(longint x);
        return (x * q_sigmoid(x)) >>> FB;
    endfunction

    function automatic longint q_softplus(longint x);
        longint thirty;
        thirty = 64'sd30 <<< FB;
        if (x > thirty) return x;
        if (x < -thirty) return q_exp(x);
        return ((x > 0) ? x : 0) + q_ln1p(q_exp((x < 0) ? x : -x));
    endfunction

    // Advance the scan state by one beat and queue the result it emits.
    task automatic scan_predict(input in_beat_t b);
        longint    delta;
        longint    decay;
        longint    abar;
        longint    xt;
        longint    bbar;
        longint    hprev;
        longint    h;
        longint    y;
        longint    g;
        int        pos;
        out_beat_t r;
        pos   = int'(b.channel) * N_SLOT + int'(b.slot);
        delta = q_softplus(longint'(b.delta_pre));
        decay = -q_exp(longint'(b.a_log));
        abar  = q_exp((delta * decay) >>> FB);
        xt    = q_silu(longint'(b.x_pre));
        bbar  = sat((delta * longint'(b.b_val)) >>> FB, S32_LO, S32_HI);
        hprev = b.first_token ? 0 : hid_mem[pos];
        h     = sat(((abar * hprev) >>> FB) + ((bbar * xt) >>> FB), S32_LO, S32_HI);
        hid_mem[pos]     = h;
        hid_written[pos] = 1'b1;
        dot_acc = sat(dot_acc + ((longint'(b.c_val) * h) >>> FB), S48_LO, S48_HI);
        if (b.last_slot) begin
            y       = sat(dot_acc + ((longint'(b.d_skip) * xt) >>> FB), S32_LO, S32_HI);
            dot_acc = 0;
            g       = sat((q_silu(longint'(b.gate_pre)) * y) >>> FB, S32_LO, S32_HI);
            r.out_channel = b.channel;
            r.scan_out    = y[31:0];
            r.gated_out   = g[31:0];
            result_q      = {result_q, r};
        end
    endtask

    // Offer one beat and wait for its handshake; valid stays up afterwards.
    task automatic send_beat(input in_beat_t b);
        // An entry that was never written must not be read back.
        if (!hid_written[int'(b.channel) * N_SLOT + int'(b.slot)]) begin
            b.first_token = 1'b1;
        end
        s_data  <= b;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        scan_predict(b);
    endtask

    task automatic idle_sender(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Stop sending until every predicted result has been seen.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (result_q.size() != 0) @(posedge aclk);
    endtask

    // Operand mix: full range, moderate Q16.16 values, or small ones.
    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return int'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
            default: return int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic in_beat_t rand_beat(input int ch, input int sl);
        in_beat_t b;
        b.channel     = ch[5:0];
        b.slot        = sl[3:0];
        b.first_token = ($urandom_range(0, 4) == 0);
        b.last_slot   = 1'b0;
        b.delta_pre   = rand_operand();
        b.a_log       = rand_operand();
        b.b_val       = rand_operand();
        b.c_val       = rand_operand();
        b.x_pre       = rand_operand();
        b.gate_pre    = rand_operand();
        b.d_skip      = rand_operand();
        return b;
    endfunction

    // Extreme operand values, each beat emitting a result.
    task automatic test_extremes();
        logic signed [31:0] ext [6];
        in_beat_t           b;
        ext = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000,
                32'sh001E_0000, -32'sh001E_0000, 32'sh0001_0000};
        for (int i = 0; i < 6; i++) begin
            b             = rand_beat(i * 12, i);
            b.first_token = 1'b1;
            b.last_slot   = 1'b1;
            b.delta_pre   = ext[i];
            b.a_log       = ext[(i + 1) % 6];
            b.b_val       = ext[(i + 2) % 6];
            b.c_val       = ext[(i + 3) % 6];
            b.x_pre       = ext[(i + 4) % 6];
            b.gate_pre    = ext[(i + 5) % 6];
            b.d_skip      = ext[i];
            send_beat(b);
        end
        b = '{channel: 6'd63, slot: 4'd15, first_token: 1'b1, last_slot: 1'b1,
              delta_pre: 32'sh7FFF_FFFF, a_log: 32'sh8000_0000, b_val: 32'sh7FFF_FFFF,
              c_val: 32'sh7FFF_FFFF, x_pre: 32'sh7FFF_FFFF, gate_pre: 32'sh8000_0000,
              d_skip: 32'sh8000_0000};
        send_beat(b);
        idle_sender(3);
    endtask

    // A missing last mark, accumulator saturation and slots out of order.
    task automatic test_scan_cases();
        in_beat_t b;
        // Accumulation across two channels without a last mark in between.
        for (int i = 0; i < 4; i++) begin
            b           = rand_beat(2 + i / 2, i % 2);
            b.last_slot = (i == 3);
            send_beat(b);
        end
        // Large h and c drive the accumulator into its 48-bit limit.
        for (int i = 0; i < 6; i++) begin
            b             = rand_beat(10, 5 - i);
            b.first_token = (i == 0);
            b.delta_pre   = 32'sh0014_0000;
            b.a_log       = 32'sh8000_0000;
            b.b_val       = 32'sh7FFF_FFFF;
            b.x_pre       = 32'sh0100_0000;
            b.c_val       = (i < 5) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            b.last_slot   = (i == 5);
            send_beat(b);
        end
        // Second token over the same entries reads back the stored state.
        for (int i = 0; i < 4; i++) begin
            b             = rand_beat(10, i);
            b.first_token = 1'b0;
            b.last_slot   = (i == 3);
            send_beat(b);
        end
    endtask

    // The receiver holds off while the sender keeps offering, then a pause.
    task automatic test_backpressure();
        in_beat_t b;
        hold_req <= hold_req + 1;
        for (int i = 0; i < 8; i++) begin
            b           = rand_beat(20 + i, 0);
            b.last_slot = 1'b1;
            send_beat(b);
        end
        wait_drained();
    endtask

    // Well-formed channel sequences with random content, plus broken ones.
    task automatic test_random_scan(input int n_items);
        int       sent;
        int       burst;
        int       ch;
        int       n_sl;
        int       kind;
        in_beat_t b;
        sent  = 0;
        burst = $urandom_range(1, 24);
        while (sent < n_items) begin
            ch   = $urandom_range(0, N_CH - 1);
            n_sl = ($urandom_range(0, 2) == 0) ? $urandom_range(1, N_SLOT) : N_SLOT;
            kind = $urandom_range(0, 9);
            for (int s = 0; s < n_sl; s++) begin
                b = rand_beat(ch, (kind == 0) ? $urandom_range(0, N_SLOT - 1) : s);
                if (s != 0 && kind != 0) b.first_token = 1'b0;
                b.last_slot = (kind == 1) ? ($urandom_range(0, 7) == 0) : (s == n_sl - 1);
                send_beat(b);
                sent++;
                burst--;
                if (burst == 0) begin
                    if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 150));
                    burst = $urandom_range(1, 24);
                end
            end
        end
    endtask

    // Receiver stall pattern, overridden by a requested hold-off.
    always @(posedge aclk) begin
        if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            case (cycles[12:11])
                2'd0:    m_ready <= 1'b1;
                2'd1:    m_ready <= $urandom_range(0, 1);
                2'd2:    m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                $error("unexpected result beat: channel %0d", m_data.out_channel);
                errors++;
            end else begin
                if (m_data.out_channel !== result_q[0].out_channel) begin
                    $error("out_channel: expected %0d, got %0d",
                           result_q[0].out_channel, m_data.out_channel);
                    errors++;
                end
                if (m_data.scan_out !== result_q[0].scan_out) begin
                    $error("scan_out: expected %0d, got %0d",
                           result_q[0].scan_out, m_data.scan_out);
                    errors++;
                end
                if (m_data.gated_out !== result_q[0].gated_out) begin
                    $error("gated_out: expected %0d, got %0d",
                           result_q[0].gated_out, m_data.gated_out);
                    errors++;
                end
                void'(result_q.pop_front());
            end
        end
    end

    initial begin
        dot_acc = 0;
        foreach (hid_mem[i]) begin
            hid_mem[i]     = 0;
            hid_written[i] = 1'b0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_scan_cases();
        test_backpressure();
        test_random_scan(RAND_ITEMS);
        wait_drained();
        repeat (TAIL_LEN) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
